FILE: design/assert_macros.svh
// assertion macros shared by the rtl of the entity decoder
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define XED_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define XED_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/xed_pkg.sv
// package for the xml entity decoder: item types, entity name table
// and the name match function; no dependencies
package xed_pkg;

   // input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // result of comparing held name bytes plus the new byte
   typedef struct packed {
      logic       full;
      logic       partial;
      logic [7:0] value;
   } match_type;

   localparam int NameCount = 6;
   localparam int NameMax   = 5;
   localparam int PrefixMax = 4;
   localparam int ListMax   = 6;

   localparam logic [7:0] CharAmp   = 8'h26;
   localparam logic [7:0] CharHash  = 8'h23;
   localparam logic [7:0] CharSemi  = 8'h3b;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   // entity names, zero padded
   localparam logic [7:0] NAME_CHARS [NameCount][NameMax] = '{
      '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},  // lt;
      '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},  // gt;
      '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},  // amp;
      '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},  // quot;
      '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},  // apos;
      '{8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}   // nbsp;
   };
   localparam logic [2:0] NAME_LENS [NameCount] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5};
   localparam logic [7:0] NAME_VALUES [NameCount] =
      '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27, 8'h20};

   // compare n held bytes and the new byte against all names in parallel
   function automatic match_type entity_match(input logic [3:0][7:0] pre,
                                              input logic [2:0] n,
                                              input logic [7:0] b);
      match_type m;
      logic      ok;
      m = '0;
      for (int i = 0; i < NameCount; i++) begin
         ok = ({1'b0, n} + 4'd1) <= {1'b0, NAME_LENS[i]};
         for (int k = 0; k < PrefixMax; k++) begin
            if (k < int'(n) && NAME_CHARS[i][k] != pre[k]) ok = 1'b0;
         end
         for (int k = 0; k < NameMax; k++) begin
            if (k == int'(n) && NAME_CHARS[i][k] != b) ok = 1'b0;
         end
         if (ok) begin
            if (({1'b0, n} + 4'd1) == {1'b0, NAME_LENS[i]}) begin
               m.full  = 1'b1;
               m.value = NAME_VALUES[i];
            end else begin
               m.partial = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

FILE: design/xml_entity_decoder.sv
// xml entity decoder: one text byte in, zero to six decoded bytes out; uses xed_pkg
// latency: the first result of an item is shown the cycle after it is taken
// throughput: one item per cycle while each gives at most one result and no
//   result stall; otherwise an item holds the six-entry result buffer until its
//   results have left, and the next item is taken in the cycle its last leaves
// reset: synchronous, clears phase, held counts, number value and result count
`include "assert_macros.svh"

module xml_entity_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  xed_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output xed_pkg::rsp_type  rsp_data
);

   typedef enum logic [1:0] {
      PH_PLAIN = 2'd0,
      PH_NAME  = 2'd1,
      PH_NUM   = 2'd2
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [3:0][7:0]  prefix_ff, prefix_in;
   logic [2:0]       prefix_count_ff, prefix_count_in;
   logic [7:0]       number_value_ff, number_value_in;

   logic [7:0]       rsp_buf_ff [xed_pkg::ListMax];
   logic [2:0]       rsp_cnt_ff;
   logic             rsp_last_ff;

   logic [7:0]       emit_list [xed_pkg::ListMax];
   logic [2:0]       emit_cnt;
   logic             emit_last;
   logic             plain_go;
   logic [7:0]       b;
   xed_pkg::match_type match;

   logic             req_take;
   logic             rsp_take;

   // handshakes
   assign rsp_valid = rsp_cnt_ff != 3'd0;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = !(rsp_cnt_ff == 3'd0 || (rsp_cnt_ff == 3'd1 && rsp_take));
   assign req_take  = req_valid && !req_stall;

   assign rsp_data.out_byte = rsp_buf_ff[0];
   assign rsp_data.out_last = rsp_last_ff && rsp_cnt_ff == 3'd1;

   assign b     = req_data.in_byte;
   assign match = xed_pkg::entity_match(prefix_ff, prefix_count_ff, b);

   // decode one byte into the list of results and the next state
   always_comb begin
      for (int i = 0; i < xed_pkg::ListMax; i++) emit_list[i] = '0;
      emit_cnt        = '0;
      plain_go        = 1'b0;
      phase_in        = phase_ff;
      prefix_in       = prefix_ff;
      prefix_count_in = prefix_count_ff;
      number_value_in = number_value_ff;

      case (phase_ff)
         PH_NAME: begin
            if (prefix_count_ff == 3'd0 && b == xed_pkg::CharHash) begin
               phase_in        = PH_NUM;
               prefix_count_in = '0;
               number_value_in = '0;
            end else if (match.full) begin
               emit_list[emit_cnt] = match.value;
               emit_cnt            = emit_cnt + 3'd1;
               phase_in            = PH_PLAIN;
               prefix_count_in     = '0;
            end else if (match.partial && prefix_count_ff < 3'd4) begin
               prefix_in[prefix_count_ff[1:0]] = b;
               prefix_count_in                 = prefix_count_ff + 3'd1;
            end else begin
               // mismatch: give back the ampersand and the held bytes
               emit_list[emit_cnt] = xed_pkg::CharAmp;
               emit_cnt            = emit_cnt + 3'd1;
               for (int k = 0; k < xed_pkg::PrefixMax; k++) begin
                  if (k < int'(prefix_count_ff)) begin
                     emit_list[emit_cnt] = prefix_ff[k];
                     emit_cnt            = emit_cnt + 3'd1;
                  end
               end
               phase_in        = PH_PLAIN;
               prefix_count_in = '0;
               plain_go        = 1'b1;
            end
         end
         PH_NUM: begin
            if (b >= xed_pkg::CharZero && b <= xed_pkg::CharNine) begin
               number_value_in = {number_value_ff[4:0], 3'b000}
                               + {number_value_ff[6:0], 1'b0}
                               + (b - xed_pkg::CharZero);
               prefix_count_in = 3'd1;
            end else begin
               // close the number, or give back a bare hash
               if (prefix_count_ff != 3'd0) begin
                  emit_list[emit_cnt] = number_value_ff;
                  emit_cnt            = emit_cnt + 3'd1;
               end else begin
                  emit_list[emit_cnt] = xed_pkg::CharAmp;
                  emit_cnt            = emit_cnt + 3'd1;
                  emit_list[emit_cnt] = xed_pkg::CharHash;
                  emit_cnt            = emit_cnt + 3'd1;
               end
               phase_in        = PH_PLAIN;
               prefix_count_in = '0;
               plain_go        = !(b == xed_pkg::CharSemi && prefix_count_ff != 3'd0);
            end
         end
         default: begin
            plain_go = 1'b1;
         end
      endcase

      // plain text handling of the byte
      if (plain_go) begin
         if (b == xed_pkg::CharAmp) begin
            phase_in        = PH_NAME;
            prefix_count_in = '0;
         end else begin
            emit_list[emit_cnt] = b;
            emit_cnt            = emit_cnt + 3'd1;
         end
      end

      // flush at end of text
      if (req_data.in_last) begin
         if (phase_in == PH_NAME) begin
            emit_list[emit_cnt] = xed_pkg::CharAmp;
            emit_cnt            = emit_cnt + 3'd1;
            for (int k = 0; k < xed_pkg::PrefixMax; k++) begin
               if (k < int'(prefix_count_in)) begin
                  emit_list[emit_cnt] = prefix_in[k];
                  emit_cnt            = emit_cnt + 3'd1;
               end
            end
         end else if (phase_in == PH_NUM) begin
            if (prefix_count_in != 3'd0) begin
               emit_list[emit_cnt] = number_value_in;
               emit_cnt            = emit_cnt + 3'd1;
            end else begin
               emit_list[emit_cnt] = xed_pkg::CharAmp;
               emit_cnt            = emit_cnt + 3'd1;
               emit_list[emit_cnt] = xed_pkg::CharHash;
               emit_cnt            = emit_cnt + 3'd1;
            end
         end
         phase_in        = PH_PLAIN;
         prefix_count_in = '0;
      end
      emit_last = req_data.in_last;
   end

   // decoder state and result count
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PLAIN;
         prefix_count_ff <= '0;
         number_value_ff <= '0;
         rsp_cnt_ff      <= '0;
      end else if (req_take) begin
         phase_ff        <= phase_in;
         prefix_count_ff <= prefix_count_in;
         number_value_ff <= number_value_in;
         rsp_cnt_ff      <= emit_cnt;
      end else if (rsp_take) begin
         rsp_cnt_ff      <= rsp_cnt_ff - 3'd1;
      end
   end

   // held name bytes and result buffer, shifted out one item at a time
   always_ff @(posedge clock) begin
      if (req_take) begin
         prefix_ff   <= prefix_in;
         rsp_last_ff <= emit_last;
         for (int i = 0; i < xed_pkg::ListMax; i++) rsp_buf_ff[i] <= emit_list[i];
      end else if (rsp_take) begin
         for (int i = 0; i < xed_pkg::ListMax - 1; i++) rsp_buf_ff[i] <= rsp_buf_ff[i + 1];
      end
   end

   `XED_ASSERT(a_cnt_range, clock, reset, rsp_cnt_ff <= 3'd6, "result count above six")
   `XED_ASSERT(a_plain_empty, clock, reset,
      phase_ff != PH_NAME && phase_ff != PH_NUM |-> prefix_count_ff == 3'd0,
      "held bytes outside an entity")
   `XED_ASSERT(a_num_flag, clock, reset,
      phase_ff == PH_NUM |-> prefix_count_ff <= 3'd1, "digit flag out of range")
   `XED_ASSERT(a_hold, clock, reset,
      rsp_valid && rsp_stall |=> $stable(rsp_cnt_ff) && $stable(rsp_buf_ff[0]),
      "result buffer moved while stalled")

endmodule

FILE: tb/xml_entity_decoder_test.sv
// self-checking testbench for the xml entity decoder: directed and random text
// streams, a byte-level decoding predictor and an in-order result check
// depends on xed_pkg and the xml_entity_decoder rtl
`timescale 1ns / 1ps

module xml_entity_decoder_test;

   typedef enum logic [1:0] {
      PHASE_PLAIN,
      PHASE_NAME,
      PHASE_NUMBER
   } phase_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   xed_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   xed_pkg::rsp_type rsp_data;

   // entity names and the bytes they stand for
   string      entity_names [6] = '{"lt;", "gt;", "amp;", "quot;", "apos;", "nbsp;"};
   logic [7:0] entity_values [6] = '{8'h3c, 8'h3e, 8'h26, 8'h22, 8'h27, 8'h20};

   // decoder state as predicted
   phase_type  dec_phase = PHASE_PLAIN;
   logic [7:0] held_chars [4];
   logic [2:0] held_count = '0;
   logic [7:0] number_acc = '0;
   logic [7:0] step_bytes [6];
   int         step_count;

   xed_pkg::req_type pending_items [$];
   xed_pkg::rsp_type expected_bytes [$];
   xed_pkg::rsp_type want;
   int      total_items = 0;
   int      items_taken = 0;
   int      mismatch_count = 0;
   logic    req_fired = 1'b0;
   logic    quiet;
   int      gap_left = 0;
   int      stall_left = 0;
   int      hold_left = 0;
   logic    pressure_done = 1'b0;

   assign quiet = (items_taken + 40 >= total_items);

   xml_entity_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   task emit_byte(input logic [7:0] b);
      if (step_count < 6) begin
         step_bytes[step_count] = b;
         step_count++;
      end
   endtask

   task plain_text(input logic [7:0] b);
      if (b == xed_pkg::CharAmp) begin
         dec_phase = PHASE_NAME;
         held_count = '0;
      end else begin
         emit_byte(b);
      end
   endtask

   // '&' and any held name bytes go out literally
   task give_back_held;
      emit_byte(xed_pkg::CharAmp);
      for (int i = 0; i < held_count && i < 4; i++) emit_byte(held_chars[i]);
      dec_phase = PHASE_PLAIN;
      held_count = '0;
   endtask

   // a number with digits gives its value, a bare hash gives "&#"
   task close_number;
      if (held_count != 0) begin
         emit_byte(number_acc);
      end else begin
         emit_byte(xed_pkg::CharAmp);
         emit_byte(xed_pkg::CharHash);
      end
      dec_phase = PHASE_PLAIN;
      held_count = '0;
   endtask

   task name_char(input logic [7:0] b);
      int         n;
      logic       ok;
      logic       partial;
      logic       full;
      logic [7:0] value;
      n = (held_count > 4) ? 4 : held_count;
      partial = 1'b0;
      full = 1'b0;
      value = '0;
      if (n == 0 && b == xed_pkg::CharHash) begin
         dec_phase = PHASE_NUMBER;
         held_count = '0;
         number_acc = '0;
      end else begin
         // compare held bytes plus this one against every name
         for (int i = 0; i < 6; i++) begin
            ok = (n + 1 <= entity_names[i].len());
            for (int k = 0; k < n; k++)
               if (ok && entity_names[i][k] != held_chars[k]) ok = 1'b0;
            if (ok && entity_names[i][n] != b) ok = 1'b0;
            if (ok) begin
               if (n + 1 == entity_names[i].len()) begin
                  full = 1'b1;
                  value = entity_values[i];
               end else begin
                  partial = 1'b1;
               end
            end
         end
         if (full) begin
            emit_byte(value);
            dec_phase = PHASE_PLAIN;
            held_count = '0;
         end else if (partial && n < 4) begin
            held_chars[n] = b;
            held_count = 3'(n + 1);
         end else begin
            give_back_held();
            plain_text(b);
         end
      end
   endtask

   // one text byte in, its decoded bytes queued as expected results
   task decode_item(input xed_pkg::req_type item);
      step_count = 0;
      case (dec_phase)
         PHASE_NAME: name_char(item.in_byte);
         PHASE_NUMBER: begin
            if (item.in_byte >= xed_pkg::CharZero && item.in_byte <= xed_pkg::CharNine) begin
               number_acc = 8'(number_acc * 10 + (item.in_byte - xed_pkg::CharZero));
               held_count = 3'd1;
            end else if (item.in_byte == xed_pkg::CharSemi && held_count != 0) begin
               close_number();
            end else begin
               close_number();
               plain_text(item.in_byte);
            end
         end
         default: plain_text(item.in_byte);
      endcase
      // flush whatever is held at the end of the text
      if (item.in_last) begin
         if (dec_phase == PHASE_NAME) give_back_held();
         else if (dec_phase == PHASE_NUMBER) close_number();
         dec_phase = PHASE_PLAIN;
         held_count = '0;
      end
      for (int i = 0; i < step_count; i++)
         expected_bytes.push_back('{out_byte: step_bytes[i],
                                    out_last: item.in_last && (i == step_count - 1)});
   endtask

   // ---------------------------------------------------------------- stimulus

   task push_byte(input logic [7:0] b);
      pending_items.push_back('{in_byte: b, in_last: 1'b0});
   endtask

   task push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // mark the most recent byte as the end of its text
   task end_text;
      xed_pkg::req_type tail;
      tail = pending_items.pop_back();
      tail.in_last = 1'b1;
      pending_items.push_back(tail);
   endtask

   initial begin
      int         kind;
      int         pick;
      int         cut;
      int         digits;
      logic       semi;
      // directed: byte extremes, full and broken names, numbers, ends of text
      push_byte(8'h00);
      push_text("&qu&amp;");
      push_text("&nbspx");
      push_text("&;");
      push_text("&#300&#");
      end_text();
      push_text("&#;");
      push_text("&lt");
      end_text();
      push_byte(8'hff);
      end_text();

      // random: mostly entity-shaped fragments with random content
      while (pending_items.size() < 220) begin
         kind = $urandom_range(0, 99);
         pick = $urandom_range(0, 5);
         if (kind < 25) begin
            push_byte(8'($urandom_range(0, 255)));
         end else if (kind < 50) begin
            push_byte(xed_pkg::CharAmp);
            push_text(entity_names[pick]);
         end else if (kind < 60) begin
            cut = $urandom_range(1, entity_names[pick].len() - 1);
            push_byte(xed_pkg::CharAmp);
            for (int j = 0; j < cut; j++) push_byte(entity_names[pick][j]);
            case ($urandom_range(0, 4))
               0: end_text();
               1: push_byte(xed_pkg::CharAmp);
               2: push_byte(xed_pkg::CharSemi);
               3: push_byte(xed_pkg::CharHash);
               default: push_byte(8'($urandom_range(0, 255)));
            endcase
         end else if (kind < 80) begin
            digits = $urandom_range(1, 4);
            semi = ($urandom_range(0, 2) != 0);
            push_byte(xed_pkg::CharAmp);
            push_byte(xed_pkg::CharHash);
            for (int j = 0; j < digits; j++)
               push_byte(8'(xed_pkg::CharZero + $urandom_range(0, 9)));
            if (semi) push_byte(xed_pkg::CharSemi);
         end else if (kind < 85) begin
            push_byte(xed_pkg::CharAmp);
            push_byte(xed_pkg::CharHash);
            push_byte(8'($urandom_range(0, 255)));
         end else if (kind < 90) begin
            push_byte(xed_pkg::CharAmp);
            push_byte(8'($urandom_range(0, 255)));
         end else begin
            for (int j = 0; j < $urandom_range(1, 3); j++)
               push_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) == 0) end_text();
      end
      total_items = pending_items.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // drain: every item taken, every result seen, then a short settle
      while (items_taken < total_items) @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   // next item once the current one is gone, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall: one long hold-off to fill the block, then random bursts
   always @(negedge clock) begin
      if (!pressure_done && items_taken >= 80) begin
         pressure_done <= 1'b1;
         hold_left <= 59;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor

   // results checked before the item taken at the same edge is predicted
   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: expected none, actual byte %h last %b",
                        $time, rsp_data.out_byte, rsp_data.out_last);
               mismatch_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %h, actual %h",
                           $time, want.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $display("%0t: out_last expected %b, actual %b",
                           $time, want.out_last, rsp_data.out_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_fired = 1'b1;
            decode_item(req_data);
            items_taken++;
         end
      end
   end

endmodule

FILE: filelist.f
+incdir+design
design/xed_pkg.sv
design/xml_entity_decoder.sv
tb/xml_entity_decoder_test.sv
